// ===== hw/rtl/rspg_pkg.sv =====
// ----------------------------------------------------------------------------
// rspg_pkg
// Types, widths and constants of the radial smearing profile generator.
// ----------------------------------------------------------------------------
package rspg_pkg;

   localparam int MAX_LATTICE = 64;

   localparam int MODE_W  = 2;
   localparam int COEF_W  = 16;
   localparam int LAT_W   = 7;
   localparam int COORD_W = 6;
   localparam int SLOT_W  = 3;
   localparam int VALUE_W = 24;
   localparam int IDX_W   = 3;
   localparam int DATA_W  = 16;

   // wrapped distance and radius
   localparam int D_W      = 8;
   localparam int S_W      = 14;
   localparam int SQ_FRAC  = 24;
   localparam int A_W      = S_W + SQ_FRAC;
   localparam int R_W      = A_W / 2;
   localparam int REM_W    = R_W + 3;
   localparam int ROOT_STEPS      = R_W;
   localparam int STEPS_PER_STAGE = 4;
   localparam int SQRT_STAGES     = (ROOT_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   // exponent argument and range reduction
   localparam int T_W      = COEF_W + R_W;
   localparam int TL_W     = 29;
   localparam int N_W      = 6;
   localparam int Y_W      = 24;
   localparam int Y0_W     = 30;
   localparam logic [Y_W-1:0]  LN2_Q24   = 24'd11629080;
   localparam logic [16:0]     LN2_RECIP = 17'd94548;
   localparam int              RECIP_SHIFT = 40;
   localparam logic [TL_W-1:0] T_LIMIT   = 29'd476792280;

   // taylor series
   localparam int TAYLOR_TERMS = 14;
   localparam int FRAC   = 30;
   localparam int TERM_W = 31;
   localparam int Y30_W  = 30;
   localparam int PROD_W = 61;
   localparam int SUM_W  = 33;
   localparam int E_W    = 17;

   // exact division by k: floor(p / k) = (p * DIV_MULT[k]) >> DIV_SHIFT[k] for p < 2^30
   localparam logic [30:0] DIV_MULT [1:TAYLOR_TERMS] = '{
      31'd1073741824, 31'd1073741824, 31'd1431655766, 31'd1073741824,
      31'd1717986919, 31'd1431655766, 31'd1227133514, 31'd1073741824,
      31'd1908874354, 31'd1717986919, 31'd1561806290, 31'd1431655766,
      31'd1321528399, 31'd1227133514};
   localparam int DIV_SHIFT [1:TAYLOR_TERMS] = '{
      30, 31, 32, 32, 33, 33, 33, 33, 34, 34, 34, 34, 34, 34};

   // polynomial and final product
   localparam int P_W     = 44;
   localparam int P_LO_W  = 22;
   localparam int PPL_W   = P_LO_W + E_W;
   localparam int PPH_W   = (P_W - P_LO_W) + E_W + 1;
   localparam int FP_W    = 62;
   localparam int RMAG_W  = FP_W - 24;

   localparam logic [VALUE_W-1:0] ONE_Q16 = 24'h010000;
   localparam logic [VALUE_W-1:0] VAL_MAX = 24'h7FFFFF;
   localparam logic [VALUE_W-1:0] VAL_MIN = 24'h800000;

   typedef enum logic [MODE_W-1:0] {
      MODE_POINT = 2'd0,
      MODE_WALL  = 2'd1,
      MODE_EXP   = 2'd2,
      MODE_POLY  = 2'd3
   } mode_type;

   typedef enum logic [IDX_W-1:0] {
      REG_MODE    = 3'd0,
      REG_DECAY   = 3'd1,
      REG_LINEAR  = 3'd2,
      REG_QUAD    = 3'd3,
      REG_LATTICE = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic                valid;
      logic [SLOT_W-1:0]   slot;
      logic                point;
      logic [S_W-1:0]      s;
      logic [REM_W-1:0]    rem;
      logic [R_W-1:0]      root;
   } sq_type;

   typedef struct packed {
      logic                valid;
      logic [SLOT_W-1:0]   slot;
      logic                point;
      logic [S_W-1:0]      s;
      logic [R_W-1:0]      r;
      logic [T_W-1:0]      t;
      logic signed [35:0]  lin_r;
      logic signed [30:0]  quad_s;
   } mul_type;

   typedef struct packed {
      logic                valid;
      logic [SLOT_W-1:0]   slot;
      logic                point;
      logic                over;
      logic [TL_W-1:0]     t;
      logic [N_W-1:0]      n;
      logic signed [P_W-1:0] p;
   } red_type;

   typedef struct packed {
      logic                valid;
      logic [SLOT_W-1:0]   slot;
      logic                point;
      logic                over;
      logic [N_W-1:0]      n;
      logic [Y0_W-1:0]     y0;
      logic signed [P_W-1:0] p;
   } rem_type;

   typedef struct packed {
      logic                valid;
      logic [SLOT_W-1:0]   slot;
      logic                point;
      logic                over;
      logic [N_W-1:0]      n;
      logic [Y30_W-1:0]    y30;
      logic signed [P_W-1:0] p;
      logic [TERM_W-1:0]   term;
      logic [PROD_W-1:0]   prod;
      logic signed [SUM_W-1:0] sum;
   } tay_type;

   typedef struct packed {
      logic                valid;
      logic [SLOT_W-1:0]   slot;
      logic                point;
      logic [E_W-1:0]      e16;
      logic signed [P_W-1:0] p;
   } exp_type;

   typedef struct packed {
      logic                valid;
      logic [SLOT_W-1:0]   slot;
      logic                point;
      logic [PPL_W-1:0]    pp_lo;
      logic signed [PPH_W-1:0] pp_hi;
   } pp_type;

   typedef struct packed {
      logic                valid;
      logic [SLOT_W-1:0]   slot;
      logic                point;
      logic                neg;
      logic [FP_W-1:0]     mag;
   } mag_type;

endpackage

// ===== hw/rtl/rspg_ifs.sv =====
// ----------------------------------------------------------------------------
// rspg channels
// Site request and profile response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rspg_req_if;
   import rspg_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] coord_x;
   logic [COORD_W-1:0] coord_y;
   logic [COORD_W-1:0] coord_z;
   logic [SLOT_W-1:0]  slot_in;

   modport source (output valid, coord_x, coord_y, coord_z, slot_in, input ready);
   modport sink   (input valid, coord_x, coord_y, coord_z, slot_in, output ready);
endinterface

interface rspg_rsp_if;
   import rspg_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [SLOT_W-1:0]         slot_out;
   logic signed [VALUE_W-1:0] profile_value;
   logic                      clipped;

   modport source (output valid, slot_out, profile_value, clipped, input ready);
   modport sink   (input valid, slot_out, profile_value, clipped, output ready);
endinterface

// ===== hw/rtl/radial_smear_profile_generator.sv =====
// Throughput: one word per cycle; the whole pipeline holds while the response
// register is full and not taken.
// Stage count is set by the 19-step square root (4 steps a stage) and the
// 14-term exponential series (multiply stage plus divide stage per term).
// Reset (synchronous): pipeline empty, registers at mode 0, decay 4096, lattice 16.
// ----------------------------------------------------------------------------
// radial_smear_profile_generator
// Pipelined fixed-point smearing source value for one lattice site per cycle.
// ----------------------------------------------------------------------------
module radial_smear_profile_generator (
   input  logic                        clock,
   input  logic                        reset,
   rspg_req_if.sink                    req,
   rspg_rsp_if.source                  rsp,
   input  logic                        csr_we,
   input  logic [rspg_pkg::IDX_W-1:0]  csr_index,
   input  logic [rspg_pkg::DATA_W-1:0] csr_wdata
);
   import rspg_pkg::*;

   mode_type            mode_ff;
   logic [COEF_W-1:0]   decay_ff;
   logic [COEF_W-1:0]   lin_ff;
   logic [COEF_W-1:0]   quad_ff;
   logic [LAT_W-1:0]    lattice_ff;

   logic                en;

   sq_type  sq_ff  [0:SQRT_STAGES];
   sq_type  sq0_in;
   mul_type mul_ff, mul_in;
   red_type red_ff, red_in;
   rem_type rem_ff, rem_in;
   tay_type tay_ff [0:2*TAYLOR_TERMS];
   tay_type tay0_in;
   exp_type exp_ff, exp_in;
   pp_type  pp_ff, pp_in;
   mag_type mag_ff, mag_in;

   logic                valid_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic                clip_ff, clip_in;

   // ---------------- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_POINT;
         decay_ff   <= 16'd4096;
         lin_ff     <= '0;
         quad_ff    <= '0;
         lattice_ff <= 7'd16;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MODE:    mode_ff    <= mode_type'(csr_wdata[MODE_W-1:0]);
            REG_DECAY:   decay_ff   <= csr_wdata;
            REG_LINEAR:  lin_ff     <= csr_wdata;
            REG_QUAD:    quad_ff    <= csr_wdata;
            REG_LATTICE: lattice_ff <= csr_wdata[LAT_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline advances unless the response word is stuck
   assign en        = !valid_ff || rsp.ready;
   assign req.ready = en;

   // ---------------- wrap and squared distance
   always_comb begin
      logic [LAT_W-1:0]     len;
      logic [LAT_W-1:0]     half;
      logic signed [D_W-1:0] dx, dy, dz;
      logic signed [2*D_W-1:0] sx, sy, sz;
      len  = (lattice_ff > LAT_W'(MAX_LATTICE)) ? LAT_W'(MAX_LATTICE) : lattice_ff;
      half = len >> 1;
      dx = (LAT_W'(req.coord_x) >= half) ? D_W'(req.coord_x) - D_W'(len) : D_W'(req.coord_x);
      dy = (LAT_W'(req.coord_y) >= half) ? D_W'(req.coord_y) - D_W'(len) : D_W'(req.coord_y);
      dz = (LAT_W'(req.coord_z) >= half) ? D_W'(req.coord_z) - D_W'(len) : D_W'(req.coord_z);
      sx = (2*D_W)'(dx) * (2*D_W)'(dy - dy + dx);
      sy = (2*D_W)'(dy) * (2*D_W)'(dy);
      sz = (2*D_W)'(dz) * (2*D_W)'(dz);
      sq0_in.valid = req.valid;
      sq0_in.slot  = req.slot_in;
      sq0_in.point = (req.coord_x == '0) && (req.coord_y == '0) && (req.coord_z == '0);
      sq0_in.s     = S_W'(sx) + S_W'(sy) + S_W'(sz);
      sq0_in.rem   = '0;
      sq0_in.root  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff[0].valid <= 1'b0;
      end else if (en) begin
         sq_ff[0] <= sq0_in;
      end
   end

   // ---------------- square root of s * 2^24, two bits a step
   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
      sq_type sq_in;

      always_comb begin
         logic [A_W-1:0]   a;
         logic [REM_W-1:0] rem_sh;
         logic [REM_W-1:0] trial;
         sq_in = sq_ff[g];
         a     = {sq_ff[g].s, {SQ_FRAC{1'b0}}};
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            if (g * STEPS_PER_STAGE + j < ROOT_STEPS) begin
               rem_sh = {sq_in.rem[REM_W-3:0],
                         2'(a >> (2 * (ROOT_STEPS - 1 - (g * STEPS_PER_STAGE + j))))};
               trial  = REM_W'({sq_in.root, 2'b01});
               if (rem_sh >= trial) begin
                  sq_in.rem  = rem_sh - trial;
                  sq_in.root = {sq_in.root[R_W-2:0], 1'b1};
               end else begin
                  sq_in.rem  = rem_sh;
                  sq_in.root = {sq_in.root[R_W-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ff[g+1].valid <= 1'b0;
         end else if (en) begin
            sq_ff[g+1] <= sq_in;
         end
      end
   end

   // ---------------- exponent argument and polynomial products
   always_comb begin
      sq_type last;
      last          = sq_ff[SQRT_STAGES];
      mul_in.valid  = last.valid;
      mul_in.slot   = last.slot;
      mul_in.point  = last.point;
      mul_in.s      = last.s;
      mul_in.r      = last.root;
      mul_in.t      = T_W'(decay_ff) * T_W'(last.root);
      mul_in.lin_r  = 36'(signed'(lin_ff)) * signed'(36'(last.root));
      mul_in.quad_s = 31'(signed'(quad_ff)) * signed'(31'(last.s));
   end

   // ---------------- reciprocal estimate of t / ln2, polynomial sum
   always_comb begin
      logic [TL_W+17-1:0] qp;
      qp           = (TL_W+17)'(mul_ff.t[TL_W-1:0]) * (TL_W+17)'(LN2_RECIP);
      red_in.valid = mul_ff.valid;
      red_in.slot  = mul_ff.slot;
      red_in.point = mul_ff.point;
      red_in.over  = (mul_ff.t >= T_W'(T_LIMIT));
      red_in.t     = mul_ff.t[TL_W-1:0];
      red_in.n     = qp[RECIP_SHIFT +: N_W];
      if (mode_ff == MODE_POLY) begin
         red_in.p = P_W'(signed'(45'd16777216)) - P_W'(mul_ff.lin_r)
                  - (P_W'(mul_ff.quad_s) <<< 12);
      end else begin
         red_in.p = P_W'(signed'(45'd16777216));
      end
   end

   // ---------------- remainder of the range reduction
   always_comb begin
      logic [Y0_W-1:0] nl;
      nl           = Y0_W'(red_ff.n) * Y0_W'(LN2_Q24);
      rem_in.valid = red_ff.valid;
      rem_in.slot  = red_ff.slot;
      rem_in.point = red_ff.point;
      rem_in.over  = red_ff.over;
      rem_in.n     = red_ff.n;
      rem_in.y0    = Y0_W'(red_ff.t) - nl;
      rem_in.p     = red_ff.p;
   end

   // estimate may be one short: one compare and subtract, then series start
   always_comb begin
      logic [Y0_W-1:0] y;
      tay0_in.valid = rem_ff.valid;
      tay0_in.slot  = rem_ff.slot;
      tay0_in.point = rem_ff.point;
      tay0_in.over  = rem_ff.over;
      tay0_in.p     = rem_ff.p;
      if (rem_ff.y0 >= Y0_W'(LN2_Q24)) begin
         y          = rem_ff.y0 - Y0_W'(LN2_Q24);
         tay0_in.n  = rem_ff.n + N_W'(1);
      end else begin
         y          = rem_ff.y0;
         tay0_in.n  = rem_ff.n;
      end
      tay0_in.y30 = {y[Y_W-1:0], 6'b0};
      tay0_in.term = TERM_W'(1) << FRAC;
      tay0_in.prod = '0;
      tay0_in.sum  = SUM_W'(1) << FRAC;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff.valid    <= 1'b0;
         red_ff.valid    <= 1'b0;
         rem_ff.valid    <= 1'b0;
         tay_ff[0].valid <= 1'b0;
      end else if (en) begin
         mul_ff    <= mul_in;
         red_ff    <= red_in;
         rem_ff    <= rem_in;
         tay_ff[0] <= tay0_in;
      end
   end

   // ---------------- taylor series of exp(-y), one term per two stages
   for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_term
      tay_type mul_st_in;
      tay_type div_st_in;

      // multiply stage; also folds the previous term into the sum
      always_comb begin
         mul_st_in = tay_ff[2*k-2];
         if (k > 1) begin
            if (((k - 1) % 2) == 1) begin
               mul_st_in.sum = tay_ff[2*k-2].sum - signed'(SUM_W'(tay_ff[2*k-2].term));
            end else begin
               mul_st_in.sum = tay_ff[2*k-2].sum + signed'(SUM_W'(tay_ff[2*k-2].term));
            end
         end
         mul_st_in.prod = PROD_W'(tay_ff[2*k-2].term) * PROD_W'(tay_ff[2*k-2].y30);
      end

      // divide stage: exact reciprocal multiply by 1/k
      always_comb begin
         logic [PROD_W-1:0] q;
         div_st_in      = tay_ff[2*k-1];
         q              = (PROD_W'(tay_ff[2*k-1].prod[FRAC +: FRAC]) * PROD_W'(DIV_MULT[k]))
                          >> DIV_SHIFT[k];
         div_st_in.term = q[TERM_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tay_ff[2*k-1].valid <= 1'b0;
            tay_ff[2*k].valid   <= 1'b0;
         end else if (en) begin
            tay_ff[2*k-1] <= mul_st_in;
            tay_ff[2*k]   <= div_st_in;
         end
      end
   end

   // ---------------- last term, scale by 2^-n with rounding
   always_comb begin
      tay_type          tl;
      logic signed [SUM_W-1:0] sum;
      logic [63:0]      acc;
      logic [63:0]      sh;
      tl  = tay_ff[2*TAYLOR_TERMS];
      sum = tl.sum + signed'(SUM_W'(tl.term));
      if (sum[SUM_W-1]) begin
         sum = '0;
      end
      acc = 64'(sum) + (64'd1 << (7'd13 + 7'(tl.n)));
      sh  = acc >> (7'd14 + 7'(tl.n));
      exp_in.valid = tl.valid;
      exp_in.slot  = tl.slot;
      exp_in.point = tl.point;
      exp_in.e16   = tl.over ? '0 : sh[E_W-1:0];
      exp_in.p     = tl.p;
   end

   // ---------------- p * e16 in two partial products
   always_comb begin
      pp_in.valid = exp_ff.valid;
      pp_in.slot  = exp_ff.slot;
      pp_in.point = exp_ff.point;
      pp_in.pp_lo = PPL_W'(exp_ff.p[P_LO_W-1:0]) * PPL_W'(exp_ff.e16);
      pp_in.pp_hi = PPH_W'(signed'(exp_ff.p[P_W-1:P_LO_W]))
                  * signed'(PPH_W'(exp_ff.e16));
   end

   always_comb begin
      logic signed [FP_W-1:0] prod;
      prod = (FP_W'(pp_ff.pp_hi) <<< P_LO_W) + signed'(FP_W'(pp_ff.pp_lo));
      mag_in.valid = pp_ff.valid;
      mag_in.slot  = pp_ff.slot;
      mag_in.point = pp_ff.point;
      mag_in.neg   = prod[FP_W-1];
      mag_in.mag   = prod[FP_W-1] ? FP_W'(-prod) : FP_W'(prod);
   end

   // ---------------- round half away from zero, saturate, pick by mode
   always_comb begin
      logic [FP_W-1:0]   rsum;
      logic [RMAG_W-1:0] rmag;
      rsum = mag_ff.mag + (FP_W'(1) << 23);
      rmag = rsum[FP_W-1:24];
      unique case (mode_ff)
         MODE_POINT: begin
            value_in = mag_ff.point ? ONE_Q16 : '0;
            clip_in  = 1'b0;
         end
         MODE_WALL: begin
            value_in = ONE_Q16;
            clip_in  = 1'b0;
         end
         default: begin
            if (mag_ff.neg) begin
               if (rmag > RMAG_W'(VAL_MIN)) begin
                  value_in = VAL_MIN;
                  clip_in  = 1'b1;
               end else begin
                  value_in = VALUE_W'(-rmag);
                  clip_in  = 1'b0;
               end
            end else begin
               if (rmag > RMAG_W'(VAL_MAX)) begin
                  value_in = VAL_MAX;
                  clip_in  = 1'b1;
               end else begin
                  value_in = rmag[VALUE_W-1:0];
                  clip_in  = 1'b0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff.valid <= 1'b0;
         pp_ff.valid  <= 1'b0;
         mag_ff.valid <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (en) begin
         exp_ff   <= exp_in;
         pp_ff    <= pp_in;
         mag_ff   <= mag_in;
         valid_ff <= mag_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         slot_ff  <= mag_ff.slot;
         value_ff <= value_in;
         clip_ff  <= clip_in;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.slot_out      = slot_ff;
   assign rsp.profile_value = value_ff;
   assign rsp.clipped       = clip_ff;

endmodule
